@@ rtl/tac_pkg.sv @@
// shared constants, status codes and calibration rom for the thermistor converter
`default_nettype none

package tac_pkg;

  localparam int AdcW    = 10;  // raw reading width
  localparam int TempW   = 14;  // output temperature width
  localparam int StatW   = 2;   // clamp status width
  localparam int RomSize = 64;  // entries held in the rom
  localparam int IdxW    = 6;   // rom index width
  localparam int DegW    = 10;  // rom temperature width, signed
  localparam int SpanW   = 6;   // widest adc span between neighbor entries

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int FRACTION_BITS_DEF = 4;

  localparam logic [StatW-1:0] STATUS_IN    = 2'd0;
  localparam logic [StatW-1:0] STATUS_BELOW = 2'd1;
  localparam logic [StatW-1:0] STATUS_ABOVE = 2'd2;

  // ascending adc codes
  localparam logic [AdcW-1:0] ROM_ADC [RomSize] = '{
    10'd23,  10'd25,  10'd27,  10'd28,  10'd31,  10'd33,  10'd35,  10'd38,
    10'd41,  10'd44,  10'd48,  10'd52,  10'd56,  10'd61,  10'd66,  10'd71,
    10'd78,  10'd84,  10'd92,  10'd100, 10'd109, 10'd120, 10'd131, 10'd143,
    10'd156, 10'd171, 10'd187, 10'd205, 10'd224, 10'd245, 10'd268, 10'd293,
    10'd320, 10'd348, 10'd379, 10'd411, 10'd445, 10'd480, 10'd516, 10'd553,
    10'd591, 10'd628, 10'd665, 10'd702, 10'd737, 10'd770, 10'd801, 10'd830,
    10'd857, 10'd881, 10'd903, 10'd922, 10'd939, 10'd954, 10'd966, 10'd977,
    10'd985, 10'd993, 10'd999, 10'd1004, 10'd1008, 10'd1012, 10'd1016, 10'd1020
  };

  // matching temperatures in whole degrees
  localparam logic signed [DegW-1:0] ROM_DEG [RomSize] = '{
    10'sd300, 10'sd295, 10'sd290, 10'sd285, 10'sd280, 10'sd275, 10'sd270, 10'sd265,
    10'sd260, 10'sd255, 10'sd250, 10'sd245, 10'sd240, 10'sd235, 10'sd230, 10'sd225,
    10'sd220, 10'sd215, 10'sd210, 10'sd205, 10'sd200, 10'sd195, 10'sd190, 10'sd185,
    10'sd180, 10'sd175, 10'sd170, 10'sd165, 10'sd160, 10'sd155, 10'sd150, 10'sd145,
    10'sd140, 10'sd135, 10'sd130, 10'sd125, 10'sd120, 10'sd115, 10'sd110, 10'sd105,
    10'sd100, 10'sd95,  10'sd90,  10'sd85,  10'sd80,  10'sd75,  10'sd70,  10'sd65,
    10'sd60,  10'sd55,  10'sd50,  10'sd45,  10'sd40,  10'sd35,  10'sd30,  10'sd25,
    10'sd20,  10'sd15,  10'sd10,  10'sd5,   10'sd0,   -10'sd5,  -10'sd10, -10'sd15
  };

endpackage

`default_nettype wire

@@ rtl/tac_div.sv @@
// restoring divider, one quotient bit per cycle, small divisor
`default_nettype none

module tac_div
  import tac_pkg::*;
#(
  parameter int QuotW = 13
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [QuotW+SpanW-1:0] dividend_i,  // top bits must be below divisor
  input  wire logic [SpanW-1:0]       divisor_i,
  output logic                        done_o,
  output logic [QuotW-1:0]            quot_o
);

  localparam int CntW = $clog2(QuotW + 1);

  logic [SpanW-1:0] rem_q, rem_d;
  logic [QuotW-1:0] dvd_q, dvd_d;
  logic [SpanW-1:0] dsr_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic [SpanW:0]   trial;
  logic             fits;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[QuotW-1]};
    fits  = trial >= {1'b0, dsr_q};
    if (fits) begin
      rem_d = SpanW'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[SpanW-1:0];
    end
    dvd_d = {dvd_q[QuotW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      rem_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q <= dividend_i[QuotW+SpanW-1:QuotW];
        dvd_q <= dividend_i[QuotW-1:0];
        dsr_q <= divisor_i;
        cnt_q <= CntW'(QuotW);
      end else if (cnt_q != '0) begin
        rem_q  <= rem_d;
        dvd_q  <= dvd_d;
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

@@ rtl/thermistor_adc_to_celsius.sv @@
// thermistor adc reading to celsius converter: rom search, interpolation, serial divide
// usage:
//   s_axis carries one raw 10-bit adc reading per request in tdata[9:0]
//   m_axis returns one result per request: temperature in 1/16 degree
//   (two's complement) in tdata[13:0] and the clamp status in tuser[1:0]
//   (0 interpolated, 1 below first rom entry, 2 above last rom entry)
//   s_axis_tready is high only while the sequencer is idle
// sequence:
//   in-table readings pass the binary search, the multiply and sum states,
//   the divider start and wait states and the done state, then enter the
//   output register; the serial divider gives one quotient bit per cycle;
//   the next request is taken only once the done state has handed the
//   result to the output register
//   clamped readings skip search and divide and go straight to the done
//   state, from which the result enters the output register once it is free
// reset:
//   rst_ni clears the sequencer, the divider and the output register
// back-pressure:
//   the result waits in the output register while the next request is
//   taken; a newer result is held in the sequencer until m_axis_tready frees it
`default_nettype none

module thermistor_adc_to_celsius
  import tac_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] adc_value, rest zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [13:0] temperature_q4, rest zero
  output logic [1:0]       m_axis_tuser    // [1:0] clamp_status
);

  // entries in use, clipped to the rom size and to at least two
  localparam int NUsed = (TABLE_ENTRIES > RomSize) ? RomSize :
                         (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUsed - 1);
  // scaled temperature and arithmetic widths
  localparam int SDegW = DegW + FRACTION_BITS;
  localparam int NumW  = SDegW + SpanW + 2;
  localparam int QuotW = SDegW - 1;
  localparam int ResW  = (SDegW > TempW) ? SDegW : TempW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_SUM,
    S_DSTART,
    S_DWAIT,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [AdcW-1:0]          raw_q;
  logic [IdxW-1:0]          lo_q, hi_q;
  logic [SpanW-1:0]         span_q;
  logic signed [SDegW-1:0]  d0_q;
  logic signed [NumW-1:0]   prod_q;
  logic [QuotW+SpanW-1:0]   mag_q;
  logic                     neg_q;
  logic [TempW-1:0]         res_temp_q;
  logic [StatW-1:0]         res_stat_q;
  logic                     out_valid_q;
  logic [TempW-1:0]         out_temp_q;
  logic [StatW-1:0]         out_stat_q;

  logic [AdcW-1:0]          adc_in;
  logic [IdxW:0]            mid_sum;
  logic [IdxW-1:0]          mid;
  logic                     le_mid;
  logic [IdxW-1:0]          idx_m1;
  logic [AdcW-1:0]          a0, a1;
  logic signed [SDegW-1:0]  d0, d1;
  logic signed [SDegW:0]    delta;
  logic [SpanW-1:0]         span, xoff;
  logic signed [NumW-1:0]   num;
  logic signed [NumW-1:0]   num_abs;
  logic signed [ResW-1:0]   clamp_lo, clamp_hi;
  logic signed [ResW-1:0]   quot_s;
  logic                     div_start;
  logic                     div_done;
  logic [QuotW-1:0]         div_quot;
  logic                     out_free;

  assign adc_in = s_axis_tdata[AdcW-1:0];

  // binary search probe
  always_comb begin
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid     = mid_sum[IdxW:1];
    le_mid  = raw_q <= ROM_ADC[mid];
  end

  // segment values around the found entry
  always_comb begin
    idx_m1 = lo_q - 1'b1;
    a0     = ROM_ADC[idx_m1];
    a1     = ROM_ADC[lo_q];
    d0     = SDegW'(ROM_DEG[idx_m1]) <<< FRACTION_BITS;
    d1     = SDegW'(ROM_DEG[lo_q]) <<< FRACTION_BITS;
    delta  = (SDegW + 1)'(d1) - (SDegW + 1)'(d0);
    span   = SpanW'(a1 - a0);
    xoff   = SpanW'(raw_q - a0);
  end

  // numerator: start temperature times span plus the interpolated part
  always_comb begin
    num     = NumW'(d0_q) * NumW'($signed({1'b0, span_q})) + prod_q;
    num_abs = (num < 0) ? -num : num;
  end

  // clamp values and signed quotient
  always_comb begin
    clamp_lo = ResW'(ROM_DEG[0]) <<< FRACTION_BITS;
    clamp_hi = ResW'(ROM_DEG[LastIdx]) <<< FRACTION_BITS;
    quot_s   = $signed(ResW'({1'b0, div_quot}));
    if (neg_q) begin
      quot_s = -quot_s;
    end
  end

  assign div_start = (state_q == S_DSTART);
  assign out_free  = !out_valid_q || m_axis_tready;

  tac_div #(
    .QuotW(QuotW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mag_q),
    .divisor_i (span_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      raw_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      span_q      <= '0;
      d0_q        <= '0;
      prod_q      <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      res_temp_q  <= '0;
      res_stat_q  <= STATUS_IN;
      out_temp_q  <= '0;
      out_stat_q  <= STATUS_IN;
    end else begin
      // taken result leaves unless a new one is loaded below
      if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            raw_q <= adc_in;
            lo_q  <= IdxW'(1);
            hi_q  <= LastIdx;
            if (adc_in < ROM_ADC[0]) begin
              res_temp_q <= clamp_lo[TempW-1:0];
              res_stat_q <= STATUS_BELOW;
              state_q    <= S_DONE;
            end else if (adc_in > ROM_ADC[LastIdx]) begin
              res_temp_q <= clamp_hi[TempW-1:0];
              res_stat_q <= STATUS_ABOVE;
              state_q    <= S_DONE;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          // first entry at or above the reading
          if (lo_q == hi_q) begin
            state_q <= S_MUL;
          end else if (le_mid) begin
            hi_q <= mid;
          end else begin
            lo_q <= mid + 1'b1;
          end
        end
        S_MUL: begin
          span_q  <= span;
          d0_q    <= d0;
          prod_q  <= NumW'($signed({1'b0, xoff})) * NumW'(delta);
          state_q <= S_SUM;
        end
        S_SUM: begin
          neg_q   <= num < 0;
          mag_q   <= num_abs[QuotW+SpanW-1:0];
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            res_temp_q <= quot_s[TempW-1:0];
            res_stat_q <= STATUS_IN;
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_temp_q  <= res_temp_q;
            out_stat_q  <= res_stat_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - TempW){1'b0}}, out_temp_q};
  assign m_axis_tuser  = out_stat_q;

endmodule

`default_nettype wire

@@ tb/thermistor_adc_to_celsius_tb.sv @@
// testbench for the thermistor converter: directed and random readings checked against a predictor
`timescale 1ns / 1ps

module thermistor_adc_to_celsius_tb;
  import tac_pkg::*;

  localparam int Scale      = 1 << FRACTION_BITS_DEF;  // one degree in output units
  localparam int CycleLimit = 400000;
  localparam int RandPerPhase = 467;                   // three phases, about 1400 readings
  localparam int DrainCycles  = 40;                    // longer than one in-table conversion

  // one result as the block should return it
  typedef struct packed {
    logic signed [TempW-1:0] temp_q4;
    logic [StatW-1:0]        status;
  } reading_result_t;

  // one row of the directed readings; known rows carry a typed-in result
  typedef struct {
    logic [AdcW-1:0]         adc;
    bit                      known;
    logic signed [TempW-1:0] temp_q4;
    logic [StatW-1:0]        status;
  } directed_row_t;

  localparam int DirRows = 21;

  // zero, all ones, both clamp edges, exact rom hits and readings between entries
  directed_row_t directed_readings [DirRows] = '{
    '{10'd0,    1'b1,  14'sd4800, STATUS_BELOW},
    '{10'd22,   1'b1,  14'sd4800, STATUS_BELOW},
    '{10'd23,   1'b1,  14'sd4800, STATUS_IN},
    '{10'd1020, 1'b1, -14'sd240,  STATUS_IN},
    '{10'd1021, 1'b1, -14'sd240,  STATUS_ABOVE},
    '{10'd1023, 1'b1, -14'sd240,  STATUS_ABOVE},
    '{10'd1008, 1'b1,  14'sd0,    STATUS_IN},
    '{10'd1004, 1'b1,  14'sd80,   STATUS_IN},
    '{10'd28,   1'b1,  14'sd4560, STATUS_IN},
    '{10'd100,  1'b1,  14'sd3280, STATUS_IN},
    '{10'd293,  1'b1,  14'sd2320, STATUS_IN},
    '{10'd1016, 1'b1, -14'sd160,  STATUS_IN},
    '{10'd24,   1'b0,  14'sd0,    STATUS_IN},
    '{10'd29,   1'b0,  14'sd0,    STATUS_IN},
    '{10'd101,  1'b0,  14'sd0,    STATUS_IN},
    '{10'd294,  1'b0,  14'sd0,    STATUS_IN},
    '{10'd512,  1'b0,  14'sd0,    STATUS_IN},
    '{10'd682,  1'b0,  14'sd0,    STATUS_IN},
    '{10'd341,  1'b0,  14'sd0,    STATUS_IN},
    '{10'd1013, 1'b0,  14'sd0,    STATUS_IN},
    '{10'd1019, 1'b0,  14'sd0,    STATUS_IN}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [9:0] adc_value, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [13:0] temperature_q4, rest zero
  logic [1:0]  m_axis_tuser;   // [1:0] clamp_status

  reading_result_t pending_temps[$];  // results owed by the block, oldest first
  int mismatches;
  int results_checked;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int below_seen;
  int above_seen;
  int inside_seen;

  thermistor_adc_to_celsius u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // table search and linear interpolation, truncated toward zero
  function automatic reading_result_t celsius_q4_of(input logic [AdcW-1:0] adc);
    reading_result_t r;
    int seg;
    int a0;
    int a1;
    int d0;
    int d1;
    int span;
    int q;
    if (int'(adc) < int'(ROM_ADC[0])) begin
      q = int'(ROM_DEG[0]) * Scale;
      r.status = STATUS_BELOW;
    end else if (int'(adc) > int'(ROM_ADC[RomSize-1])) begin
      q = int'(ROM_DEG[RomSize-1]) * Scale;
      r.status = STATUS_ABOVE;
    end else begin
      // first entry at or above the reading, starting from the second one
      seg = 1;
      while (seg < RomSize - 1 && int'(adc) > int'(ROM_ADC[seg])) seg++;
      a0 = int'(ROM_ADC[seg-1]);
      a1 = int'(ROM_ADC[seg]);
      d0 = int'(ROM_DEG[seg-1]) * Scale;
      d1 = int'(ROM_DEG[seg]) * Scale;
      span = a1 - a0;
      if (span <= 0) begin
        q = d1;
      end else begin
        q = (d0 * span + (int'(adc) - a0) * (d1 - d0)) / span;
      end
      r.status = STATUS_IN;
    end
    r.temp_q4 = q[TempW-1:0];
    return r;
  endfunction

  // random reading: mostly inside the table, with weight on rom entries and clamp zones
  function automatic logic [AdcW-1:0] pick_reading();
    int idx;
    int v;
    case ($urandom_range(9))
      0: v = $urandom_range(int'(ROM_ADC[0]) - 1);
      1: v = $urandom_range(1023, int'(ROM_ADC[RomSize-1]) + 1);
      2, 3: begin
        idx = $urandom_range(RomSize - 1);
        v = int'(ROM_ADC[idx]) + $urandom_range(2) - 1;
      end
      default: v = $urandom_range(1023);
    endcase
    return v[AdcW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
  endtask

  // offer one reading, with random idle cycles ahead of it, and log what it owes
  task automatic send_reading(input logic [AdcW-1:0] adc, input reading_result_t owed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(16-AdcW){1'b0}}, adc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_temps.push_back(owed);
    case (owed.status)
      STATUS_BELOW: below_seen++;
      STATUS_ABOVE: above_seen++;
      default:      inside_seen++;
    endcase
  endtask

  // result side: compare each accepted result, then pick the next ready level
  always @(posedge clk_i) begin
    reading_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_temps.size() == 0) begin
        report_mismatch("result with nothing pending, tdata", int'(m_axis_tdata), 0);
      end else begin
        want = pending_temps.pop_front();
        results_checked++;
        if (m_axis_tdata !== {{(16-TempW){1'b0}}, want.temp_q4})
          report_mismatch("temperature_q4", int'(m_axis_tdata),
                          int'(want.temp_q4));
        if (m_axis_tuser !== want.status)
          report_mismatch("clamp_status", int'(m_axis_tuser), int'(want.status));
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("thermistor_adc_to_celsius_tb: FAIL");
      $finish;
    end
  end

  initial begin
    reading_result_t owed;
    logic [AdcW-1:0] adc;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    cycle_count     = 0;
    below_seen      = 0;
    above_seen      = 0;
    inside_seen     = 0;
    send_idle_pct   = 32;
    recv_idle_pct   = 63;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed readings
    foreach (directed_readings[i]) begin
      if (directed_readings[i].known) begin
        owed.temp_q4 = directed_readings[i].temp_q4;
        owed.status  = directed_readings[i].status;
      end else begin
        owed = celsius_q4_of(directed_readings[i].adc);
      end
      send_reading(directed_readings[i].adc, owed);
    end

    // random readings: receiver-heavy idling, then sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 32; recv_idle_pct = 63; end
        1: begin send_idle_pct = 63; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        adc = pick_reading();
        send_reading(adc, celsius_q4_of(adc));
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give a stray extra result time to show up
    while (pending_temps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("readings sent: %0d below table, %0d above table, %0d inside table",
             below_seen, above_seen, inside_seen);
    $display("results checked: %0d, mismatches: %0d, cycles: %0d",
             results_checked, mismatches, cycle_count);
    if (mismatches == 0 && pending_temps.size() == 0) begin
      $display("thermistor_adc_to_celsius_tb: PASS");
    end else begin
      $display("thermistor_adc_to_celsius_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ thermistor_adc_to_celsius.f @@
rtl/tac_pkg.sv
rtl/tac_div.sv
rtl/thermistor_adc_to_celsius.sv
tb/thermistor_adc_to_celsius_tb.sv
